/* src/erc_pkg.sv */
// ----------------------------------------------------------------------------
// erc_pkg
// Types and constants shared by the event rate counter modules.
// ----------------------------------------------------------------------------
package erc_pkg;

  localparam int unsigned STAMP_W  = 32;
  localparam int unsigned PERIOD_W = 16;
  localparam int unsigned SCALE_W  = 10;
  localparam int unsigned NUM_W    = STAMP_W + SCALE_W;
  localparam int unsigned STEP_W   = $clog2(NUM_W);

  localparam logic [SCALE_W-1:0]  EVENT_SCALE  = 10'd1000;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd1000;
  localparam logic [STAMP_W-1:0]  MAX32        = '1;
  localparam logic [STEP_W-1:0]   DIV_LAST     = STEP_W'(NUM_W - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_MUL,
    ST_DIV,
    ST_PUSH
  } erc_state_t;

  typedef struct packed {
    logic capture;
    logic eval;
    logic mul;
    logic div_step;
    logic push;
  } erc_cmd_t;

  typedef struct packed {
    logic reach;
    logic div_last;
    logic out_free;
  } erc_status_t;

endpackage

/* src/erc_channels.sv */
// ----------------------------------------------------------------------------
// erc channels
// Valid/ready channels for event items and rate results.
// ----------------------------------------------------------------------------
interface erc_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [31:0] now_ms;

  modport source (output valid, output op, output now_ms, input ready);
  modport sink   (input valid, input op, input now_ms, output ready);
endinterface

interface erc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] rate;
  logic        rate_updated;

  modport source (output valid, output rate, output rate_updated, input ready);
  modport sink   (input valid, input rate, input rate_updated, output ready);
endinterface

/* src/event_rate_counter.sv */
// ----------------------------------------------------------------------------
// event_rate_counter
// Events-per-second meter over millisecond timestamps.
//
// Input channel in_ch carries op (0 start, 1 tick) and now_ms. Each transfer
// gives exactly one result on out_ch: rate and rate_updated.
// cfg_we/cfg_wdata write period_ms; write only while no item is in flight.
//
// Sequence: a start, or a tick that does not close the period, is captured,
// evaluated and handed over to the output register. A tick that closes the
// period also scales its event count by 1000 and runs a 42-step restoring
// divide (one quotient bit per cycle) by the elapsed time before hand-over.
// Items are processed one at a time; in_ch.ready is high whenever the
// sequencer is idle, even while a result waits in the output register.
// Receiver stall: the output register holds its result and the next item
// waits at its final hand-over step until the register frees.
// Reset: period_ms returns to 1000 and all measurement state clears.
// ----------------------------------------------------------------------------
module event_rate_counter
  import erc_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  erc_in_if.sink              in_ch,
  erc_out_if.source           out_ch,
  input  logic                cfg_we,
  input  logic [PERIOD_W-1:0] cfg_wdata
);

  erc_cmd_t    cmd;
  erc_status_t status;

  erc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .cmd      (cmd),
    .status   (status)
  );

  erc_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_op            (in_ch.op),
    .in_now_ms        (in_ch.now_ms),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .cmd              (cmd),
    .status           (status),
    .out_ready        (out_ch.ready),
    .out_valid        (out_ch.valid),
    .out_rate         (out_ch.rate),
    .out_rate_updated (out_ch.rate_updated)
  );

endmodule

/* src/erc_ctrl.sv */
// ----------------------------------------------------------------------------
// erc_ctrl
// Sequencer: capture, evaluate, multiply, divide and hand over one item.
// ----------------------------------------------------------------------------
module erc_ctrl
  import erc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  output erc_cmd_t    cmd,
  input  erc_status_t status
);

  erc_state_t state_r;
  erc_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = status.reach ? ST_MUL : ST_PUSH;
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_nxt = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (status.out_free) begin
          cmd.push  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

/* src/erc_dp.sv */
// ----------------------------------------------------------------------------
// erc_dp
// Datapath: measurement state, period register, restoring divider, result
// register.
// ----------------------------------------------------------------------------
module erc_dp
  import erc_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_op,
  input  logic [STAMP_W-1:0]  in_now_ms,
  input  logic                cfg_we,
  input  logic [PERIOD_W-1:0] cfg_wdata,
  input  erc_cmd_t            cmd,
  output erc_status_t         status,
  input  logic                out_ready,
  output logic                out_valid,
  output logic [STAMP_W-1:0]  out_rate,
  output logic                out_rate_updated
);

  logic [PERIOD_W-1:0] period_r;
  logic                op_r;
  logic [STAMP_W-1:0]  now_r;
  logic [STAMP_W-1:0]  last_r;
  logic [STAMP_W-1:0]  elapsed_r;
  logic [STAMP_W-1:0]  count_r;
  logic [STAMP_W-1:0]  rate_r;
  logic                updated_r;
  logic [NUM_W-1:0]    quo_r;
  logic [STAMP_W-1:0]  rem_r;
  logic [STEP_W-1:0]   step_r;
  logic                out_valid_r;
  logic [STAMP_W-1:0]  out_rate_r;
  logic                out_updated_r;

  logic [STAMP_W-1:0]  delta;
  logic [STAMP_W:0]    el_sum;
  logic [STAMP_W-1:0]  elapsed_nxt;
  logic [STAMP_W-1:0]  count_nxt;
  logic [STAMP_W-1:0]  limit;
  logic [STAMP_W:0]    rem_sh;
  logic                ge;
  logic [STAMP_W-1:0]  rem_nxt;
  logic [NUM_W-1:0]    quo_nxt;
  logic [STAMP_W-1:0]  rate_sat;

  always_comb begin
    delta       = now_r - last_r;
    el_sum      = {1'b0, elapsed_r} + {1'b0, delta};
    elapsed_nxt = el_sum[STAMP_W] ? MAX32 : el_sum[STAMP_W-1:0];
    count_nxt   = (count_r == MAX32) ? MAX32 : count_r + STAMP_W'(1);
    limit       = (period_r == '0) ? STAMP_W'(1) : STAMP_W'(period_r);
    rem_sh      = {rem_r, quo_r[NUM_W-1]};
    ge          = rem_sh >= {1'b0, elapsed_r};
    rem_nxt     = ge ? STAMP_W'(rem_sh - {1'b0, elapsed_r}) : rem_sh[STAMP_W-1:0];
    quo_nxt     = {quo_r[NUM_W-2:0], ge};
    rate_sat    = (quo_nxt[NUM_W-1:STAMP_W] != '0) ? MAX32 : quo_nxt[STAMP_W-1:0];
  end

  assign status.reach    = op_r && (elapsed_nxt >= limit);
  assign status.div_last = (step_r == DIV_LAST);
  assign status.out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= PERIOD_RESET;
    end else if (cfg_we) begin
      period_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r  <= in_op;
      now_r <= in_now_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r    <= '0;
      elapsed_r <= '0;
      count_r   <= '0;
      rate_r    <= '0;
      updated_r <= 1'b0;
    end else if (cmd.eval) begin
      last_r    <= now_r;
      updated_r <= 1'b0;
      if (op_r) begin
        elapsed_r <= elapsed_nxt;
        count_r   <= count_nxt;
      end else begin
        elapsed_r <= '0;
        count_r   <= '0;
        rate_r    <= '0;
      end
    end else if (cmd.div_step && status.div_last) begin
      rate_r    <= rate_sat;
      elapsed_r <= '0;
      count_r   <= '0;
      updated_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      quo_r  <= NUM_W'(count_r) * NUM_W'(EVENT_SCALE);
      rem_r  <= '0;
      step_r <= '0;
    end else if (cmd.div_step) begin
      quo_r  <= quo_nxt;
      rem_r  <= rem_nxt;
      step_r <= step_r + STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.push) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_rate_r    <= rate_r;
      out_updated_r <= updated_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_rate         = out_rate_r;
  assign out_rate_updated = out_updated_r;

`ifndef ASSERT_OFF
  a_push_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> (!out_valid_r || out_ready))
    else $error("result loaded over an untaken transfer");

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |-> (elapsed_r != '0))
    else $error("divide with zero divisor");

  a_div_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.div_step && status.div_last) |=> (elapsed_r == '0 && count_r == '0 && updated_r))
    else $error("window not cleared after rate update");

  a_mul_after_reach: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mul |-> $past(cmd.eval && status.reach))
    else $error("divide started without period reached");
`endif

endmodule
